[rtl/i2c_master_transfer_sequencer_unit_assert.svh]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define I2CM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CM_ASSERT(lbl, expr, msg)
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Field widths, request and action codes, status codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 4;
  localparam int PTR_W        = 5;
  localparam int LEN_W        = 5;
  localparam int REQ_W        = 2;
  localparam int ACT_W        = 3;
  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;

  localparam logic [PTR_W-1:0]  PTR_INC     = PTR_W'(1);
  localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hF8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RD_ACK  = 3'd3,
    ACT_RD_NACK = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_RELEASE = 3'd6
  } act_t;

  localparam logic [BYTE_W-1:0] ST_BUS_ERR     = 8'h00;
  localparam logic [BYTE_W-1:0] ST_START       = 8'h08;
  localparam logic [BYTE_W-1:0] ST_REP_START   = 8'h10;
  localparam logic [BYTE_W-1:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [BYTE_W-1:0] ST_SLAW_NACK   = 8'h20;
  localparam logic [BYTE_W-1:0] ST_TXDATA_ACK  = 8'h28;
  localparam logic [BYTE_W-1:0] ST_TXDATA_NACK = 8'h30;
  localparam logic [BYTE_W-1:0] ST_ARB_LOST    = 8'h38;
  localparam logic [BYTE_W-1:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [BYTE_W-1:0] ST_SLAR_NACK   = 8'h48;
  localparam logic [BYTE_W-1:0] ST_RDATA_ACK   = 8'h50;
  localparam logic [BYTE_W-1:0] ST_RDATA_NACK  = 8'h58;
  localparam logic [BYTE_W-1:0] ST_NO_INFO     = 8'hF8;

  typedef struct packed {
    act_t             action;
    logic             tx_wr;
    logic             tx_rd;
    logic [PTR_W-1:0] tx_ptr;
    logic             rx_wr;
    logic [PTR_W-1:0] rx_ptr;
    logic             rx_rd;
    logic             busy;
    logic             success;
    logic             acc;
  } seq_cmd_t;

  typedef struct packed {
    act_t action;
    logic tx_sel;
    logic rx_sel;
    logic busy;
    logic success;
    logic acc;
  } stage_t;

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer channel interfaces
// Request and result channels with valid/ready handshake per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
  logic                           valid;
  logic                           ready;
  logic [i2cm_pkg::REQ_W-1:0]     req_type;
  logic [i2cm_pkg::IDX_W-1:0]     entry_index;
  logic [i2cm_pkg::BYTE_W-1:0]    entry_byte;
  logic [i2cm_pkg::LEN_W-1:0]     msg_length;
  logic [i2cm_pkg::BYTE_W-1:0]    bus_status;
  logic [i2cm_pkg::BYTE_W-1:0]    bus_rx_byte;

  modport source (
    output valid, req_type, entry_index, entry_byte, msg_length, bus_status, bus_rx_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_byte, msg_length, bus_status, bus_rx_byte,
    output ready
  );
endinterface

interface i2cm_res_if;
  logic                           valid;
  logic                           ready;
  logic [i2cm_pkg::ACT_W-1:0]     bus_action;
  logic [i2cm_pkg::BYTE_W-1:0]    send_byte;
  logic                           busy_res;
  logic                           transfer_ok;
  logic [i2cm_pkg::BYTE_W-1:0]    rx_read_byte;
  logic                           accepted;

  modport source (
    output valid, bus_action, send_byte, busy_res, transfer_ok, rx_read_byte, accepted,
    input  ready
  );
  modport sink (
    input  valid, bus_action, send_byte, busy_res, transfer_ok, rx_read_byte, accepted,
    output ready
  );
endinterface

`default_nettype wire

[rtl/i2cm_ram.sv]
// ----------------------------------------------------------------------------
// I2C master byte buffer RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_ram #(
  parameter int DEPTH = i2cm_pkg::TX_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [i2cm_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [i2cm_pkg::BYTE_W-1:0] rd_data
);

  logic [i2cm_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/i2cm_seq.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer control
// Decodes each request word, updates pointer, length and flags, and issues
// buffer accesses and the next bus action.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq #(
  parameter int TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = i2cm_pkg::RX_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire logic [i2cm_pkg::REQ_W-1:0]  req_type,
  input  wire logic [i2cm_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [i2cm_pkg::LEN_W-1:0]  msg_length,
  input  wire logic [i2cm_pkg::BYTE_W-1:0] bus_status,
  output i2cm_pkg::seq_cmd_t               cmd
);

  logic [i2cm_pkg::PTR_W-1:0]  byte_ptr_r, byte_ptr_nxt;
  logic [i2cm_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                        busy_r, busy_nxt;
  logic                        success_r, success_nxt;
  logic [i2cm_pkg::BYTE_W-1:0] code;
  logic [i2cm_pkg::PTR_W-1:0]  ptr_eff;
  logic [i2cm_pkg::PTR_W-1:0]  ptr_inc;

  always_comb begin
    code     = bus_status & i2cm_pkg::STATUS_MASK;
    ptr_eff  = ((code == i2cm_pkg::ST_START) || (code == i2cm_pkg::ST_REP_START)) ?
               '0 : byte_ptr_r;
    ptr_inc  = i2cm_pkg::PTR_W'(ptr_eff + i2cm_pkg::PTR_INC);

    byte_ptr_nxt = byte_ptr_r;
    len_nxt      = len_r;
    busy_nxt     = busy_r;
    success_nxt  = success_r;
    cmd          = '0;
    cmd.action   = i2cm_pkg::ACT_NONE;
    cmd.tx_ptr   = ptr_eff;
    cmd.rx_ptr   = byte_ptr_r;

    case (i2cm_pkg::req_t'(req_type))
      i2cm_pkg::REQ_LOAD: begin
        if (!busy_r && (32'(entry_index) < TX_DEPTH)) begin
          cmd.tx_wr = 1'b1;
          cmd.acc   = 1'b1;
        end
      end
      i2cm_pkg::REQ_START: begin
        if (!busy_r) begin
          len_nxt     = msg_length;
          success_nxt = 1'b0;
          busy_nxt    = 1'b1;
          cmd.action  = i2cm_pkg::ACT_START;
          cmd.acc     = 1'b1;
        end
      end
      i2cm_pkg::REQ_STATUS: begin
        cmd.acc = 1'b1;
        case (code)
          i2cm_pkg::ST_START, i2cm_pkg::ST_REP_START,
          i2cm_pkg::ST_SLAW_ACK, i2cm_pkg::ST_TXDATA_ACK: begin
            if (ptr_eff < len_r) begin
              cmd.action   = i2cm_pkg::ACT_SEND;
              cmd.tx_rd    = (32'(ptr_eff) < TX_DEPTH);
              byte_ptr_nxt = ptr_inc;
            end else begin
              byte_ptr_nxt = ptr_eff;
              success_nxt  = 1'b1;
              busy_nxt     = 1'b0;
              cmd.action   = i2cm_pkg::ACT_STOP;
            end
          end
          i2cm_pkg::ST_SLAW_NACK, i2cm_pkg::ST_TXDATA_NACK, i2cm_pkg::ST_ARB_LOST: begin
            busy_nxt   = 1'b1;
            cmd.action = i2cm_pkg::ACT_START;
          end
          i2cm_pkg::ST_RDATA_ACK: begin
            cmd.rx_wr    = (32'(byte_ptr_r) < RX_DEPTH);
            byte_ptr_nxt = ptr_inc;
            cmd.action   = (ptr_inc < len_r) ? i2cm_pkg::ACT_RD_ACK : i2cm_pkg::ACT_RD_NACK;
          end
          i2cm_pkg::ST_SLAR_ACK: begin
            cmd.action = (byte_ptr_r < len_r) ? i2cm_pkg::ACT_RD_ACK : i2cm_pkg::ACT_RD_NACK;
          end
          i2cm_pkg::ST_SLAR_NACK: begin
            busy_nxt   = 1'b0;
            cmd.action = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_RDATA_NACK: begin
            success_nxt = 1'b1;
            busy_nxt    = 1'b0;
            cmd.action  = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_BUS_ERR: begin
            busy_nxt   = 1'b1;
            cmd.action = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_NO_INFO: begin
            busy_nxt   = 1'b0;
            cmd.action = i2cm_pkg::ACT_RELEASE;
          end
          default: begin
            cmd.action = i2cm_pkg::ACT_NONE;
          end
        endcase
      end
      i2cm_pkg::REQ_READ: begin
        cmd.acc   = 1'b1;
        cmd.rx_rd = (32'(entry_index) < RX_DEPTH);
      end
      default: begin
        cmd.acc = 1'b0;
      end
    endcase

    cmd.busy    = busy_nxt;
    cmd.success = success_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_ptr_r <= '0;
      len_r      <= '0;
      busy_r     <= 1'b0;
      success_r  <= 1'b0;
    end else if (fire) begin
      byte_ptr_r <= byte_ptr_nxt;
      len_r      <= len_nxt;
      busy_r     <= busy_nxt;
      success_r  <= success_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/i2c_master_transfer_sequencer_unit.sv]
// Each accepted request word passes through the stage register s1 and then the output
// register before its result is valid; a stalled output holds both. Throughput: one
// request word per cycle unless the output stalls; pointer, length and flags update
// in one read-modify-write and each buffer RAM has one read and one write port.
// Reset clears the byte pointer, length, busy and success flags and the pipeline
// valids; the tx and rx buffers are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Top level: control decode, tx and rx buffer RAMs, and a two-entry output path.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2c_master_transfer_sequencer_unit #(
  parameter int TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = i2cm_pkg::RX_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  i2cm_req_if.sink   in_if,
  i2cm_res_if.source out_if
);

  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  i2cm_pkg::seq_cmd_t          cmd;
  i2cm_pkg::stage_t            s1_r, s1_nxt;
  logic                        s1_v_r;
  logic                        out_v_r;
  logic                        in_fire;
  logic                        s1_move;
  logic [i2cm_pkg::BYTE_W-1:0] tx_q;
  logic [i2cm_pkg::BYTE_W-1:0] rx_q;
  i2cm_pkg::act_t              out_action_r;
  logic [i2cm_pkg::BYTE_W-1:0] out_send_r;
  logic [i2cm_pkg::BYTE_W-1:0] out_rx_r;
  logic                        out_busy_r;
  logic                        out_ok_r;
  logic                        out_acc_r;

  assign s1_move      = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !s1_v_r || s1_move;
  assign in_fire      = in_if.valid && in_if.ready;

  i2cm_seq #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .req_type   (in_if.req_type),
    .entry_index(in_if.entry_index),
    .msg_length (in_if.msg_length),
    .bus_status (in_if.bus_status),
    .cmd        (cmd)
  );

  i2cm_ram #(
    .DEPTH(TX_DEPTH),
    .AW   (TX_AW)
  ) u_tx_ram (
    .clk    (clk),
    .wr_en  (in_fire && cmd.tx_wr),
    .wr_addr(TX_AW'(in_if.entry_index)),
    .wr_data(in_if.entry_byte),
    .rd_en  (in_fire && cmd.tx_rd),
    .rd_addr(TX_AW'(cmd.tx_ptr)),
    .rd_data(tx_q)
  );

  i2cm_ram #(
    .DEPTH(RX_DEPTH),
    .AW   (RX_AW)
  ) u_rx_ram (
    .clk    (clk),
    .wr_en  (in_fire && cmd.rx_wr),
    .wr_addr(RX_AW'(cmd.rx_ptr)),
    .wr_data(in_if.bus_rx_byte),
    .rd_en  (in_fire && cmd.rx_rd),
    .rd_addr(RX_AW'(in_if.entry_index)),
    .rd_data(rx_q)
  );

  always_comb begin
    s1_nxt.action  = cmd.action;
    s1_nxt.tx_sel  = cmd.tx_rd;
    s1_nxt.rx_sel  = cmd.rx_rd;
    s1_nxt.busy    = cmd.busy;
    s1_nxt.success = cmd.success;
    s1_nxt.acc     = cmd.acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_action_r <= s1_r.action;
      out_send_r   <= s1_r.tx_sel ? tx_q : '0;
      out_rx_r     <= s1_r.rx_sel ? rx_q : '0;
      out_busy_r   <= s1_r.busy;
      out_ok_r     <= s1_r.success;
      out_acc_r    <= s1_r.acc;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.bus_action   = out_action_r;
  assign out_if.send_byte    = out_send_r;
  assign out_if.busy_res     = out_busy_r;
  assign out_if.transfer_ok  = out_ok_r;
  assign out_if.rx_read_byte = out_rx_r;
  assign out_if.accepted     = out_acc_r;

  `I2CM_ASSERT(a_ready_only_when_full, !in_if.ready |-> (s1_v_r && out_v_r), "input stalled with room")
  `I2CM_ASSERT_NEXT(a_stage_held, s1_v_r && out_v_r && !out_if.ready, s1_v_r && $stable(s1_r), "stage lost while stalled")
  `I2CM_ASSERT(a_reject_no_action, (out_v_r && !out_acc_r) |-> (out_action_r == i2cm_pkg::ACT_NONE), "rejected word has action")
  `I2CM_ASSERT(a_send_only_on_action, (out_v_r && (out_send_r != '0)) |-> (out_action_r == i2cm_pkg::ACT_SEND), "send byte without send action")
  `I2CM_ASSERT(a_tx_single_access, !(in_fire && cmd.tx_wr && cmd.tx_rd), "tx write and read in one word")

endmodule

`default_nettype wire

[tb/tb_i2c_master_transfer_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// A directed table of requests, then random read and write transfers and noise.
// Each accepted request word updates a shadow model that predicts its result.
// Result words are compared field by field against the predicted queue.
// ----------------------------------------------------------------------------

module tb_i2c_master_transfer_sequencer_unit;

  localparam int TX_SLOTS     = i2cm_pkg::TX_DEPTH_DEF;
  localparam int RX_SLOTS     = i2cm_pkg::RX_DEPTH_DEF;
  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTS  = 10;
  localparam logic [i2cm_pkg::BYTE_W-1:0] ST_UNLISTED = 8'h60;

  typedef struct packed {
    i2cm_pkg::req_t              req;
    logic [i2cm_pkg::IDX_W-1:0]  idx;
    logic [i2cm_pkg::BYTE_W-1:0] data;
    logic [i2cm_pkg::LEN_W-1:0]  len;
    logic [i2cm_pkg::BYTE_W-1:0] status;
    logic [i2cm_pkg::BYTE_W-1:0] rx_data;
  } bus_req_t;

  typedef struct packed {
    i2cm_pkg::act_t              action;
    logic [i2cm_pkg::BYTE_W-1:0] send_byte;
    logic                        busy;
    logic                        ok;
    logic [i2cm_pkg::BYTE_W-1:0] rx_read;
    logic                        accepted;
  } bus_result_t;

  typedef struct {
    bus_req_t    word;
    bit          known;
    bus_result_t result;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cm_req_if req_ch ();
  i2cm_res_if res_ch ();

  i2c_master_transfer_sequencer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source)
  );

  always #6 clk = ~clk;

  logic [i2cm_pkg::BYTE_W-1:0] tx_shadow [TX_SLOTS];
  logic [i2cm_pkg::BYTE_W-1:0] rx_shadow [RX_SLOTS];
  bit                          rx_filled [RX_SLOTS];
  logic [i2cm_pkg::PTR_W-1:0]  ptr_shadow  = '0;
  logic [i2cm_pkg::LEN_W-1:0]  len_shadow  = '0;
  bit                          busy_shadow = 1'b0;
  bit                          ok_shadow   = 1'b0;

  bus_result_t pending_bus_results [$];
  table_row_t  stim_table [$];
  int mismatches    = 0;
  int words_sent    = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 61;
  int cycle_count   = 0;
  bit hold_request  = 1'b0;

  function automatic bus_result_t next_bus_result(input bus_req_t w);
    bus_result_t r;
    logic [i2cm_pkg::BYTE_W-1:0] code;
    r = '0;
    r.action = i2cm_pkg::ACT_NONE;
    case (w.req)
      i2cm_pkg::REQ_LOAD: begin
        if (!busy_shadow) begin
          tx_shadow[w.idx] = w.data;
          r.accepted = 1'b1;
        end
      end
      i2cm_pkg::REQ_START: begin
        if (!busy_shadow) begin
          len_shadow  = w.len;
          ok_shadow   = 1'b0;
          busy_shadow = 1'b1;
          r.action    = i2cm_pkg::ACT_START;
          r.accepted  = 1'b1;
        end
      end
      i2cm_pkg::REQ_STATUS: begin
        r.accepted = 1'b1;
        code = w.status & i2cm_pkg::STATUS_MASK;
        case (code)
          i2cm_pkg::ST_START, i2cm_pkg::ST_REP_START,
          i2cm_pkg::ST_SLAW_ACK, i2cm_pkg::ST_TXDATA_ACK: begin
            if (code == i2cm_pkg::ST_START || code == i2cm_pkg::ST_REP_START) begin
              ptr_shadow = '0;
            end
            if (ptr_shadow < len_shadow) begin
              r.action = i2cm_pkg::ACT_SEND;
              r.send_byte = (ptr_shadow < TX_SLOTS) ?
                            tx_shadow[ptr_shadow[i2cm_pkg::IDX_W-1:0]] : '0;
              ptr_shadow = ptr_shadow + i2cm_pkg::PTR_INC;
            end else begin
              ok_shadow   = 1'b1;
              busy_shadow = 1'b0;
              r.action    = i2cm_pkg::ACT_STOP;
            end
          end
          i2cm_pkg::ST_SLAW_NACK, i2cm_pkg::ST_TXDATA_NACK, i2cm_pkg::ST_ARB_LOST: begin
            busy_shadow = 1'b1;
            r.action    = i2cm_pkg::ACT_START;
          end
          i2cm_pkg::ST_RDATA_ACK, i2cm_pkg::ST_SLAR_ACK: begin
            if (code == i2cm_pkg::ST_RDATA_ACK) begin
              if (ptr_shadow < RX_SLOTS) begin
                rx_shadow[ptr_shadow[i2cm_pkg::IDX_W-1:0]] = w.rx_data;
                rx_filled[ptr_shadow[i2cm_pkg::IDX_W-1:0]] = 1'b1;
              end
              ptr_shadow = ptr_shadow + i2cm_pkg::PTR_INC;
            end
            r.action = (ptr_shadow < len_shadow) ? i2cm_pkg::ACT_RD_ACK :
                                                   i2cm_pkg::ACT_RD_NACK;
          end
          i2cm_pkg::ST_SLAR_NACK: begin
            busy_shadow = 1'b0;
            r.action    = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_RDATA_NACK: begin
            ok_shadow   = 1'b1;
            busy_shadow = 1'b0;
            r.action    = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_BUS_ERR: begin
            busy_shadow = 1'b1;
            r.action    = i2cm_pkg::ACT_STOP;
          end
          i2cm_pkg::ST_NO_INFO: begin
            busy_shadow = 1'b0;
            r.action    = i2cm_pkg::ACT_RELEASE;
          end
          default: r.action = i2cm_pkg::ACT_NONE;
        endcase
      end
      default: begin
        r.accepted = 1'b1;
        r.rx_read  = rx_shadow[w.idx];
      end
    endcase
    r.busy = busy_shadow;
    r.ok   = ok_shadow;
    return r;
  endfunction

  function automatic string result_text(input bus_result_t r);
    return $sformatf("action=%0d send=%02h busy=%0b ok=%0b rx=%02h accepted=%0b",
                     r.action, r.send_byte, r.busy, r.ok, r.rx_read, r.accepted);
  endfunction

  function automatic table_row_t row(input i2cm_pkg::req_t rq, input int idx, input int data,
                                     input int len, input int code, input int rxd,
                                     input bit known, input i2cm_pkg::act_t act,
                                     input bit busy, input bit ok, input bit acc);
    table_row_t t;
    t.word   = '{rq, i2cm_pkg::IDX_W'(idx), i2cm_pkg::BYTE_W'(data),
                 i2cm_pkg::LEN_W'(len), i2cm_pkg::BYTE_W'(code), i2cm_pkg::BYTE_W'(rxd)};
    t.known  = known;
    t.result = '{act, '0, busy, ok, '0, acc};
    return t;
  endfunction

  function automatic bus_req_t random_word();
    bus_req_t w;
    w.req     = i2cm_pkg::req_t'($urandom_range(3));
    w.idx     = i2cm_pkg::IDX_W'($urandom_range(15));
    w.data    = i2cm_pkg::BYTE_W'($urandom_range(255));
    w.len     = i2cm_pkg::LEN_W'($urandom_range(31));
    w.status  = i2cm_pkg::BYTE_W'($urandom_range(255));
    w.rx_data = i2cm_pkg::BYTE_W'($urandom_range(255));
    return w;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return $urandom_range(17, 31);
  endfunction

  task automatic send_word(input bus_req_t w, input bit known, input bus_result_t typed);
    bus_result_t predicted;
    int slots [$];
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    // A read request may only address receive slots that hold data.
    if (w.req == i2cm_pkg::REQ_READ && !rx_filled[w.idx]) begin
      for (int i = 0; i < RX_SLOTS; i++) if (rx_filled[i]) slots.push_back(i);
      if (slots.size() == 0) w.req = i2cm_pkg::REQ_STATUS;
      else w.idx = i2cm_pkg::IDX_W'(slots[$urandom_range(slots.size() - 1)]);
    end
    req_ch.req_type    <= w.req;
    req_ch.entry_index <= w.idx;
    req_ch.entry_byte  <= w.data;
    req_ch.msg_length  <= w.len;
    req_ch.bus_status  <= w.status;
    req_ch.bus_rx_byte <= w.rx_data;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predicted = next_bus_result(w);
    pending_bus_results.push_back(known ? typed : predicted);
    words_sent++;
  endtask

  task automatic send_status(input logic [i2cm_pkg::BYTE_W-1:0] code);
    bus_req_t w;
    w = random_word();
    w.req = i2cm_pkg::REQ_STATUS;
    w.status = code | i2cm_pkg::BYTE_W'($urandom_range(7));
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_start(input int len);
    bus_req_t w;
    w = random_word();
    w.req = i2cm_pkg::REQ_START;
    w.len = i2cm_pkg::LEN_W'(len);
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_load(input int idx);
    bus_req_t w;
    w = random_word();
    w.req = i2cm_pkg::REQ_LOAD;
    w.idx = i2cm_pkg::IDX_W'(idx);
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_read();
    bus_req_t w;
    w = random_word();
    w.req = i2cm_pkg::REQ_READ;
    send_word(w, 1'b0, '0);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bus_results.size() != 0);
  endtask

  task automatic run_write_transfer();
    int errs;
    errs = 0;
    if (busy_shadow) send_status(i2cm_pkg::ST_NO_INFO);
    repeat ($urandom_range(0, 3)) send_load($urandom_range(15));
    send_start(pick_len());
    send_status(($urandom_range(3) == 0) ? i2cm_pkg::ST_REP_START : i2cm_pkg::ST_START);
    while (busy_shadow) begin
      if (errs < 2 && $urandom_range(99) < 4) begin
        errs++;
        send_status(($urandom_range(2) == 0) ? i2cm_pkg::ST_SLAW_NACK :
                    (($urandom_range(1) == 0) ? i2cm_pkg::ST_TXDATA_NACK :
                                                 i2cm_pkg::ST_ARB_LOST));
        send_status(i2cm_pkg::ST_REP_START);
      end else begin
        send_status((ptr_shadow == i2cm_pkg::PTR_INC) ? i2cm_pkg::ST_SLAW_ACK :
                                                        i2cm_pkg::ST_TXDATA_ACK);
      end
    end
  endtask

  task automatic run_read_transfer();
    int len;
    int extra;
    if (busy_shadow) send_status(i2cm_pkg::ST_NO_INFO);
    len = pick_len();
    send_start(len);
    send_status(i2cm_pkg::ST_START);
    if (!busy_shadow) return;
    if ($urandom_range(99) < 8) begin
      send_status(i2cm_pkg::ST_SLAR_NACK);
      return;
    end
    send_status(i2cm_pkg::ST_SLAR_ACK);
    extra = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    repeat (len - 1 + extra) send_status(i2cm_pkg::ST_RDATA_ACK);
    send_status(i2cm_pkg::ST_RDATA_NACK);
    repeat ($urandom_range(0, 2)) send_read();
  endtask

  initial begin : result_side
    bus_result_t got;
    bus_result_t want;
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got.action    = i2cm_pkg::act_t'(res_ch.bus_action);
        got.send_byte = res_ch.send_byte;
        got.busy      = res_ch.busy_res;
        got.ok        = res_ch.transfer_ok;
        got.rx_read   = res_ch.rx_read_byte;
        got.accepted  = res_ch.accepted;
        if (pending_bus_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result word with nothing pending: %s", result_text(got));
        end else begin
          want = pending_bus_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected %s, got %s",
                       result_text(want), result_text(got));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int first_random;
    int phase;
    int pick;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= i2cm_pkg::REQ_LOAD;
    req_ch.entry_index <= '0;
    req_ch.entry_byte  <= '0;
    req_ch.msg_length  <= '0;
    req_ch.bus_status  <= '0;
    req_ch.bus_rx_byte <= '0;

    stim_table.push_back(row(i2cm_pkg::REQ_LOAD, 0, 8'hA1, 0, 0, 0,
                             1, i2cm_pkg::ACT_NONE, 0, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_LOAD, 1, 8'hFF, 0, 0, 0,
                             1, i2cm_pkg::ACT_NONE, 0, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_LOAD, 15, 8'h00, 0, 0, 0,
                             1, i2cm_pkg::ACT_NONE, 0, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_START, 0, 0, 2, 0, 0,
                             1, i2cm_pkg::ACT_START, 1, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_LOAD, 2, 8'h55, 0, 0, 0,
                             1, i2cm_pkg::ACT_NONE, 1, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_START, 0, 0, 31, 0, 0,
                             1, i2cm_pkg::ACT_NONE, 1, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_START, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_SLAW_ACK | 8'h07, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_TXDATA_ACK, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_START, 0, 0, 3, 0, 0,
                             1, i2cm_pkg::ACT_START, 1, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_SLAW_NACK, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_REP_START, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_TXDATA_NACK, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_ARB_LOST, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_SLAR_ACK, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_RDATA_ACK, 8'hFF,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_RDATA_ACK, 8'h00,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_RDATA_NACK, 8'h5A,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_READ, 1, 0, 0, 0, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_READ, 2, 0, 0, 0, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_SLAR_NACK, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_BUS_ERR, 0,
                             1, i2cm_pkg::ACT_STOP, 1, 1, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, ST_UNLISTED, 0,
                             1, i2cm_pkg::ACT_NONE, 1, 1, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_NO_INFO | 8'h07, 0,
                             1, i2cm_pkg::ACT_RELEASE, 0, 1, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_START, 0, 0, 0, 0, 0,
                             1, i2cm_pkg::ACT_START, 1, 0, 1));
    stim_table.push_back(row(i2cm_pkg::REQ_STATUS, 0, 0, 0, i2cm_pkg::ST_START, 0,
                             0, i2cm_pkg::ACT_NONE, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].known,
                                      stim_table[i].result);

    first_random = words_sent;
    phase = 0;
    for (int i = 0; i < TX_SLOTS; i++) send_load(i);
    while (words_sent - first_random < RANDOM_WORDS) begin
      if (phase == 0 && words_sent - first_random >= RANDOM_WORDS / 3) begin
        phase = 1;
        wait_all_results();
        send_idle_pct = 61;
        recv_idle_pct = 12;
      end else if (phase == 1 && words_sent - first_random >= 2 * RANDOM_WORDS / 3) begin
        phase = 2;
        wait_all_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 40) run_write_transfer();
      else if (pick < 75) run_read_transfer();
      else if (pick < 85) repeat ($urandom_range(1, 4)) send_read();
      else repeat ($urandom_range(1, 6)) send_word(random_word(), 1'b0, '0);
    end

    wait_all_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
